// ===== rtl/core/nlbc_pkg.sv =====
// Shared constants and a character helper for the number literal base converter.
package nlbc_pkg;
  localparam logic [1:0] BASE_BIN = 2'd0;
  localparam logic [1:0] BASE_OCT = 2'd1;
  localparam logic [1:0] BASE_DEC = 2'd2;
  localparam logic [1:0] BASE_HEX = 2'd3;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_Q     = 8'h71;

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    hex_char = (d < 4'd10) ? (CH_ZERO + {4'd0, d}) : (8'd55 + {4'd0, d});
  endfunction
endpackage

// ===== rtl/core/nlbc_parse.sv =====
// Per-character accumulation and base detection for one literal.
`default_nettype none
module nlbc_parse
  import nlbc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        take,
  input  wire logic [7:0]  in_char,
  input  wire logic        is_final,
  output logic             match,
  output logic [1:0]       base,
  output logic [31:0]      value
);
  logic [31:0] bin_acc, oct_acc, dec_acc, hex_acc;
  logic [1:0]  len;
  logic [1:0]  pfx;
  logic [3:0]  ok;
  logic        isdig, isoct, ishex, hexp;
  logic [3:0]  hv;
  logic [1:0]  pfx_n;
  logic [3:0]  ok_n;
  logic [1:0]  len_n;

  always_comb begin
    isdig = (in_char >= 8'd48) && (in_char <= 8'd57);
    isoct = (in_char >= 8'd48) && (in_char <= 8'd55);
    ishex = 1'b1;
    hv = 4'd0;
    if (isdig) hv = in_char[3:0];
    else if (in_char >= 8'd65 && in_char <= 8'd70) hv = 4'(in_char - 8'd55);
    else if (in_char >= 8'd97 && in_char <= 8'd102) hv = 4'(in_char - 8'd87);
    else ishex = 1'b0;
    pfx_n = pfx;
    if (len == 2'd0)
      pfx_n = {(in_char == 8'h30) || (in_char == 8'h4F), in_char == 8'h30};
    else if (len == 2'd1 && !(in_char == 8'h78 || in_char == 8'h58))
      pfx_n[1] = 1'b0;
    ok_n = ok;
    if (!(in_char == 8'h30 || in_char == 8'h31)) ok_n[0] = 1'b0;
    if (!isdig) ok_n[2] = 1'b0;
    if (len == 2'd3 || len == 2'd2) begin
      if (!ishex) ok_n[3] = 1'b0;
    end
    if (!is_final && !isoct) ok_n[1] = 1'b0;
    len_n = (len == 2'd3) ? len : len + 2'd1;
    hexp = (len_n == 2'd3) && pfx_n[1] && ok_n[3];
    match = 1'b1;
    base = BASE_DEC;
    value = dec_acc * 32'd10 + (isdig ? {28'd0, in_char[3:0]} : 32'd0);
    if (hexp) begin
      base = BASE_HEX;
      value = (len >= 2'd2) ? {hex_acc[27:0], hv} : hex_acc;
    end else if (in_char == CH_Q && len_n >= 2'd2 && ok_n[1]) begin
      base = BASE_OCT;
      value = oct_acc;
    end else if (pfx_n[0] && ok_n[0]) begin
      base = BASE_BIN;
      value = {bin_acc[30:0], in_char == 8'h31};
    end else if (!ok_n[2]) begin
      match = 1'b0;
      base = BASE_BIN;
      value = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (take && is_final)) begin
      bin_acc <= '0; oct_acc <= '0; dec_acc <= '0; hex_acc <= '0;
      len <= '0; pfx <= '0; ok <= '1;
    end else if (take) begin
      bin_acc <= {bin_acc[30:0], in_char == 8'h31};
      dec_acc <= dec_acc * 32'd10 + (isdig ? {28'd0, in_char[3:0]} : 32'd0);
      if (len >= 2'd2) hex_acc <= {hex_acc[27:0], hv};
      oct_acc <= {oct_acc[28:0], isoct ? in_char[2:0] : 3'd0};
      len <= len_n; pfx <= pfx_n; ok <= ok_n;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/nlbc_emit.sv =====
// Output sequencer: shifts digits out, decimal by repeated subtract of powers of ten.
`default_nettype none
module nlbc_emit
  import nlbc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        match,
  input  wire logic [1:0]  base,
  input  wire logic [31:0] value,
  input  wire logic [1:0]  opcode,
  output logic             busy,
  output logic             valid,
  input  wire logic        ready,
  output logic [7:0]       out_char,
  output logic             status,
  output logic [1:0]       detected_base,
  output logic [31:0]      number_value,
  output logic             run_end
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_DSUB = 3'd2;
  localparam logic [2:0] S_OUT  = 3'd3;

  logic [2:0]  state;
  logic [1:0]  op;
  logic        ok;
  logic [31:0] sh;    // shifting copy or decimal remainder
  logic [5:0]  cnt;
  logic [3:0]  dig;
  logic [3:0]  pidx;
  logic        lead;
  logic [31:0] pw;

  always_comb begin
    unique case (pidx)
      4'd9: pw = 32'd1000000000;
      4'd8: pw = 32'd100000000;
      4'd7: pw = 32'd10000000;
      4'd6: pw = 32'd1000000;
      4'd5: pw = 32'd100000;
      4'd4: pw = 32'd10000;
      4'd3: pw = 32'd1000;
      4'd2: pw = 32'd100;
      4'd1: pw = 32'd10;
      default: pw = 32'd1;
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (start) begin
          op <= opcode; ok <= match; status <= !match;
          detected_base <= base; number_value <= value; cnt <= '0;
          sh <= value; lead <= 1'b1; pidx <= 4'd9; dig <= '0;
          state <= S_PREP;
        end
        S_PREP: begin
          if (!ok) begin
            out_char <= 8'd0; run_end <= 1'b1; valid <= 1'b1; state <= S_OUT;
          end else if (op == BASE_DEC) begin
            if (sh[31]) begin
              sh <= 32'd0 - sh;
              out_char <= CH_MINUS; run_end <= 1'b0; valid <= 1'b1; state <= S_OUT;
            end else state <= S_DSUB;
          end else begin
            unique case (op)
              BASE_BIN: begin
                if (cnt[5:0] == 6'd8 || cnt == 6'd17 || cnt == 6'd26 || cnt == 6'd35) begin
                  out_char <= CH_SPACE;
                end else begin
                  out_char <= sh[31] ? 8'h31 : 8'h30; sh <= {sh[30:0], 1'b0};
                end
                run_end <= (cnt == 6'd35);
              end
              BASE_OCT: begin
                if (cnt == 6'd0) begin
                  out_char <= CH_ZERO + {6'd0, sh[31:30]}; sh <= {sh[29:0], 2'b0};
                end else begin
                  out_char <= CH_ZERO + {5'd0, sh[31:29]}; sh <= {sh[28:0], 3'b0};
                end
                run_end <= (cnt == 6'd10);
              end
              default: begin
                out_char <= hex_char(sh[31:28]); sh <= {sh[27:0], 4'b0};
                run_end <= (cnt == 6'd7);
              end
            endcase
            cnt <= cnt + 6'd1; valid <= 1'b1; state <= S_OUT;
          end
        end
        S_DSUB: begin
          // subtract one power of ten a cycle; digit done when it no longer fits
          if (sh >= pw) begin
            sh <= sh - pw; dig <= dig + 4'd1;
          end else begin
            if (!lead || dig != 4'd0 || pidx == 4'd0) begin
              lead <= 1'b0;
              out_char <= CH_ZERO + {4'd0, dig};
              run_end <= (pidx == 4'd0);
              valid <= 1'b1; state <= S_OUT;
            end
            dig <= '0;
            if (pidx != 4'd0) pidx <= pidx - 4'd1;
          end
        end
        S_OUT: if (ready) begin
          valid <= 1'b0;
          if (run_end) state <= S_IDLE;
          else if (op == BASE_DEC) state <= S_DSUB;
          else state <= S_PREP;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/number_literal_base_converter_top.sv =====
// Top level of the number literal base converter.
// Usage: feed an ASCII literal one character per item on the input channel
// (in_char, is_final, opcode; in_valid/in_ready). Non-final characters are
// taken in one cycle each and produce nothing. The final character selects
// the target base through opcode; the block detects the source base and
// then sends the value as a run of ASCII characters on the output channel
// (out_valid/out_ready), run_end high on the last one. While a run is being
// formed or sent in_ready is low.
// Binary, octal and hex runs hold 36, 11 or 8 characters; decimal
// digits come from a shared subtract-and-compare unit stepping
// through powers of ten. A literal that matches no base gives one result.
// A receiver stall holds the current character unchanged in the output
// register. Reset clears all literal state and drops any run in progress.
`default_nettype none
module number_literal_base_converter_top
  import nlbc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_char,
  input  wire logic        is_final,
  input  wire logic [1:0]  opcode,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_char,
  output logic             status,
  output logic [1:0]       detected_base,
  output logic [31:0]      number_value,
  output logic             run_end
);
  logic        take, busy, match;
  logic [1:0]  base;
  logic [31:0] value;

  assign in_ready = !busy;
  assign take = in_valid && in_ready;

  nlbc_parse u_parse (
    .clk, .rst, .take, .in_char, .is_final, .match, .base, .value
  );

  nlbc_emit u_emit (
    .clk, .rst, .start(take && is_final), .match, .base, .value, .opcode,
    .busy, .valid(out_valid), .ready(out_ready), .out_char, .status,
    .detected_base, .number_value, .run_end
  );
endmodule
`default_nettype wire
